[rtl/cvs_pkg.sv]
package cvs_pkg;

	localparam int DIM        = 128;
	localparam int CAP        = 1024;
	localparam int MAX_TOP_K  = 16;
	localparam int PEND_DEPTH = 16;

	localparam int DIMI_W = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CNT_W  = $clog2(DIM + 2);
	localparam int CAP_W  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int PD_W   = $clog2(PEND_DEPTH + 1);
	localparam int PI_W   = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
	localparam int EA_W   = (CAP * DIM > 1) ? $clog2(CAP * DIM) : 1;
	localparam int PA_W   = (PEND_DEPTH * DIM > 1) ? $clog2(PEND_DEPTH * DIM) : 1;
	localparam int KW     = $clog2(MAX_TOP_K + 1);

	localparam int ACC_W    = 32 + $clog2(DIM);
	localparam int SQ_STEPS = (ACC_W + 1) / 2;
	localparam int SQ_W     = SQ_STEPS;
	localparam int DEN_W    = 2 * SQ_W;
	localparam int Q_W      = 20;
	localparam int DIV_W    = DEN_W + Q_W;
	localparam int ST_W     = $clog2(SQ_STEPS + Q_W + 1);

	localparam int ID_W    = 64;
	localparam int EL_W    = 16;
	localparam int SC_W    = 18;
	localparam int RANK_W  = 4;
	localparam int SC_ONE  = 65536;

	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_COMMIT   = 3'd2,
		CMD_ROLLBACK = 3'd3,
		CMD_QUERY    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_DIM        = 3'd1,
		ST_PEND_FULL  = 3'd2,
		ST_STORE_FULL = 3'd3,
		ST_NO_MATCH   = 3'd4
	} status_t;

	typedef struct packed {
		logic [ACC_W-1:0] x;
		logic [ACC_W-1:0] r;
	} sq_t;

	// One digit pair of the floor square root.
	function automatic sq_t isqrt_step(input sq_t cur, input logic [ACC_W-1:0] b);
		sq_t nxt;
		logic [ACC_W-1:0] t;
		t = cur.r + b;
		if (cur.x >= t) begin
			nxt.x = cur.x - t;
			nxt.r = (cur.r >> 1) + b;
		end else begin
			nxt.x = cur.x;
			nxt.r = cur.r >> 1;
		end
		return nxt;
	endfunction

	function automatic logic ranks_above(input logic signed [SC_W-1:0] s1,
		input logic [ID_W-1:0] id1, input logic signed [SC_W-1:0] s2,
		input logic [ID_W-1:0] id2);
		logic r;
		if (s1 != s2) begin
			r = s1 > s2;
		end else begin
			r = id1 < id2;
		end
		return r;
	endfunction

endpackage

[rtl/cvs_ram.sv]
module cvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/cosine_topk_vector_search.sv]
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   cmd, item_id, element, last_element, result_limit
// out       source     out_valid / out_ready status, match_id, score, rank, final_result,
//                                            pending_total
// cfg       sink       cfg_valid / cfg_ready cfg_data (dims_in_use)
//
// A non-final element leaves in_ready high for the next; remove, rollback and most closes go through S_EMIT.
// Closing an add with dims_in_use below DIM zero-fills the rest of the staged vector.
// Commit handles each staged op in turn (slot scan, then, for an add, element copy).
// A query walks every slot; the time spent on a stored one is
// set by the element memory port and the bit-serial square root and divider.
// After reset a clearing pass empties every slot of the slot table; in_ready stays low meanwhile.
module cosine_topk_vector_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         cmd,
	input  logic [cvs_pkg::ID_W-1:0]           item_id,
	input  logic signed [cvs_pkg::EL_W-1:0]    element,
	input  logic                               last_element,
	input  logic [4:0]                         result_limit,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic [cvs_pkg::ID_W-1:0]           match_id,
	output logic signed [cvs_pkg::SC_W-1:0]    score,
	output logic [cvs_pkg::RANK_W-1:0]         rank,
	output logic                               final_result,
	output logic [4:0]                         pending_total,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [7:0]                         cfg_data
);

	localparam int DIM    = cvs_pkg::DIM;
	localparam int CAP    = cvs_pkg::CAP;
	localparam int TOPK   = cvs_pkg::MAX_TOP_K;
	localparam int PD     = cvs_pkg::PEND_DEPTH;
	localparam int CNT_W  = cvs_pkg::CNT_W;
	localparam int CAP_W  = cvs_pkg::CAP_W;
	localparam int PD_W   = cvs_pkg::PD_W;
	localparam int PI_W   = cvs_pkg::PI_W;
	localparam int DIMI_W = cvs_pkg::DIMI_W;
	localparam int EA_W   = cvs_pkg::EA_W;
	localparam int PA_W   = cvs_pkg::PA_W;
	localparam int KW     = cvs_pkg::KW;
	localparam int ACC_W  = cvs_pkg::ACC_W;
	localparam int SQ_W   = cvs_pkg::SQ_W;
	localparam int DEN_W  = cvs_pkg::DEN_W;
	localparam int Q_W    = cvs_pkg::Q_W;
	localparam int DIV_W  = cvs_pkg::DIV_W;
	localparam int ST_W   = cvs_pkg::ST_W;
	localparam int ID_W   = cvs_pkg::ID_W;
	localparam int EL_W   = cvs_pkg::EL_W;
	localparam int SC_W   = cvs_pkg::SC_W;
	localparam int RANK_W = cvs_pkg::RANK_W;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_ZERO, S_EMIT,
		S_CM_OP, S_CM_SCAN, S_CM_COPY,
		S_Q_SLOT, S_Q_CHK, S_Q_ACC, S_Q_SQRT, S_Q_MUL, S_Q_DINIT, S_Q_DIV, S_Q_FIN,
		S_Q_INS, S_Q_OUT
	} state_t;

	typedef struct packed {
		logic            rm;
		logic [ID_W-1:0] id;
	} pop_t;

	state_t                 state_q;
	logic [7:0]             dims_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   gq_q;
	logic [PD_W-1:0]        fill_q;
	cvs_pkg::status_t       status_q;
	logic [ID_W-1:0]        id_q;
	logic [KW-1:0]          limit_q;
	logic [KW-1:0]          found_q;
	logic [KW-1:0]          out_i_q;
	logic [CNT_W-1:0]       zero_i_q;
	logic [CAP_W-1:0]       clr_q;

	// commit
	logic [PI_W-1:0]        op_i_q;
	logic                   op_rm_q;
	logic [ID_W-1:0]        op_id_q;
	logic                   fail_q;
	logic [CAP_W:0]         iss_q;
	logic                   rdv_s1;
	logic [CAP_W-1:0]       rda_s1;
	logic                   free_v_q;
	logic [CAP_W-1:0]       free_a_q;
	logic [CAP_W-1:0]       tgt_q;
	logic [DIMI_W:0]        cp_i_q;
	logic                   cpv_s1;
	logic [DIMI_W-1:0]      cpa_s1;

	// query scoring
	logic [CAP_W-1:0]       slot_q;
	logic [ID_W-1:0]        sid_q;
	logic [EA_W-1:0]        base_q;
	logic [CNT_W-1:0]       qi_q;
	logic                   qv_s1;
	logic                   v_s2;
	logic signed [31:0]     pd_s2;
	logic [31:0]            pa_s2;
	logic [31:0]            pb_s2;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0]       na_q;
	logic [ACC_W-1:0]       nb_q;
	cvs_pkg::sq_t           sqa_q;
	cvs_pkg::sq_t           sqb_q;
	logic [ACC_W-1:0]       bit_q;
	logic [ST_W-1:0]        step_q;
	logic [DEN_W-1:0]       den_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       dsh_q;
	logic [Q_W-1:0]         quo_q;
	logic signed [SC_W-1:0] score_q;

	logic signed [SC_W-1:0] best_sc [TOPK];
	logic [ID_W-1:0]        best_id [TOPK];
	pop_t                   pend_ops [PD];

	// output register
	logic                   out_valid_q;
	cvs_pkg::status_t       out_st_q;
	logic [ID_W-1:0]        out_id_q;
	logic signed [SC_W-1:0] out_sc_q;
	logic [RANK_W-1:0]      out_rank_q;
	logic                   out_fin_q;
	logic [4:0]             out_pend_q;

	// memory ports
	logic                   slot_we;
	logic [CAP_W-1:0]       slot_waddr;
	logic [ID_W:0]          slot_wdata;
	logic [CAP_W-1:0]       slot_raddr;
	logic [ID_W:0]          slot_rd;
	logic                   elem_we;
	logic [EA_W-1:0]        elem_waddr;
	logic [EA_W-1:0]        elem_raddr;
	logic [EL_W-1:0]        elem_rd;
	logic                   pend_we;
	logic [PA_W-1:0]        pend_waddr;
	logic [EL_W-1:0]        pend_wdata;
	logic [PA_W-1:0]        pend_raddr;
	logic [EL_W-1:0]        pend_rd;
	logic                   qry_we;
	logic [DIMI_W-1:0]      qry_waddr;
	logic [DIMI_W-1:0]      qry_raddr;
	logic [EL_W-1:0]        qry_rd;

	logic                   accept;
	logic                   load_ok;
	logic                   as_q;
	logic [CNT_W-1:0]       cnt_base;
	logic [CNT_W-1:0]       cnt_new;
	logic                   dims_ok;
	logic                   pend_full;
	logic [KW-1:0]          lim_sat;

	logic                   sc_issue;
	logic                   hit;
	logic                   free_here;
	logic                   scan_end;
	logic                   cp_issue;
	logic                   copy_done;
	logic                   cm_next;
	logic                   cm_fail;
	logic                   cm_copy;
	logic [CAP_W-1:0]       cm_tgt;
	logic                   q_issue;

	cvs_pkg::sq_t           sqa_n;
	cvs_pkg::sq_t           sqb_n;
	logic [ACC_W-1:0]       mag;
	logic [DIV_W-1:0]       dsub;
	logic                   dge;
	logic [Q_W-1:0]         qsat;

	logic [TOPK-1:0]        nab;
	logic [KW-1:0]          ins_j;
	logic                   ins_ok;

	logic                   pq_we;
	pop_t                   pq_wdata;

	logic signed [EL_W-1:0] qs;
	logic signed [EL_W-1:0] es;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign load_ok   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign match_id      = out_id_q;
	assign score         = out_sc_q;
	assign rank          = out_rank_q;
	assign final_result  = out_fin_q;
	assign pending_total = out_pend_q;

	// Element gathering: a switch of kind mid-vector restarts the count.
	always_comb begin
		as_q     = (cmd == cvs_pkg::CMD_QUERY);
		cnt_base = (cnt_q != '0 && gq_q != as_q) ? '0 : cnt_q;
		cnt_new  = (32'(cnt_base) <= DIM) ? cnt_base + 1'b1 : cnt_base;
		dims_ok  = (dims_q != 8'd0) && (32'(dims_q) <= DIM) && (32'(cnt_new) == 32'(dims_q));
		pend_full = (32'(fill_q) >= PD);
		lim_sat  = (32'(result_limit) > TOPK) ? KW'(TOPK) : KW'(result_limit);
	end

	// Commit scan decisions on the slot word read back for the address issued the cycle before.
	always_comb begin
		sc_issue  = (state_q == S_CM_SCAN) && (32'(iss_q) < CAP);
		hit       = rdv_s1 && slot_rd[ID_W] && (slot_rd[ID_W-1:0] == op_id_q);
		free_here = rdv_s1 && !slot_rd[ID_W];
		scan_end  = rdv_s1 && (rda_s1 == CAP_W'(CAP - 1));
		cp_issue  = (state_q == S_CM_COPY) && (32'(cp_i_q) < DIM);
		copy_done = (state_q == S_CM_COPY) && cpv_s1 && (cpa_s1 == DIMI_W'(DIM - 1));
		cm_next   = 1'b0;
		cm_fail   = 1'b0;
		cm_copy   = 1'b0;
		cm_tgt    = rda_s1;
		if (state_q == S_CM_SCAN) begin
			if (hit) begin
				if (op_rm_q) begin
					cm_next = 1'b1;
				end else begin
					cm_copy = 1'b1;
				end
			end else if (scan_end) begin
				if (op_rm_q) begin
					cm_next = 1'b1;
				end else if (free_v_q || free_here) begin
					cm_copy = 1'b1;
					cm_tgt  = free_v_q ? free_a_q : rda_s1;
				end else begin
					cm_next = 1'b1;
					cm_fail = 1'b1;
				end
			end
		end
		if (copy_done) begin
			cm_next = 1'b1;
		end
	end

	// Scoring arithmetic.
	always_comb begin
		q_issue = (state_q == S_Q_ACC) && (32'(qi_q) < 32'(dims_q));
		qs      = qry_rd;
		es      = elem_rd;
		sqa_n   = cvs_pkg::isqrt_step(sqa_q, bit_q);
		sqb_n   = cvs_pkg::isqrt_step(sqb_q, bit_q);
		mag     = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);
		dge     = rem_q >= dsh_q;
		dsub    = rem_q - dsh_q;
		qsat    = (32'(quo_q) > cvs_pkg::SC_ONE) ? Q_W'(cvs_pkg::SC_ONE) : quo_q;
	end

	// Rank insertion: count the kept entries that stay ahead of the new score.
	always_comb begin
		for (int p = 0; p < TOPK; p++) begin
			nab[p] = (32'(found_q) > p) &&
				!cvs_pkg::ranks_above(score_q, sid_q, best_sc[p], best_id[p]);
		end
		ins_j  = KW'($countones(nab));
		ins_ok = ins_j < limit_q;
	end

	// Memory port steering.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = clr_q;
		slot_wdata = '0;
		slot_raddr = (state_q == S_CM_SCAN) ? iss_q[CAP_W-1:0] : slot_q;
		if (state_q == S_CLEAR) begin
			slot_we = 1'b1;
		end else if (state_q == S_CM_SCAN && hit && op_rm_q) begin
			slot_we    = 1'b1;
			slot_waddr = rda_s1;
			slot_wdata = {1'b0, op_id_q};
		end else if (copy_done) begin
			slot_we    = 1'b1;
			slot_waddr = tgt_q;
			slot_wdata = {1'b1, op_id_q};
		end

		elem_we    = (state_q == S_CM_COPY) && cpv_s1;
		elem_waddr = EA_W'(tgt_q) * EA_W'(DIM) + EA_W'(cpa_s1);
		elem_raddr = base_q + EA_W'(qi_q);

		pend_we    = 1'b0;
		pend_waddr = PA_W'(fill_q) * PA_W'(DIM) + PA_W'(cnt_base);
		pend_wdata = element;
		pend_raddr = PA_W'(op_i_q) * PA_W'(DIM) + PA_W'(cp_i_q[DIMI_W-1:0]);
		if (accept && cmd == cvs_pkg::CMD_ADD && 32'(cnt_base) < DIM && !pend_full) begin
			pend_we = 1'b1;
		end else if (state_q == S_ZERO) begin
			pend_we    = 1'b1;
			pend_waddr = PA_W'(fill_q) * PA_W'(DIM) + PA_W'(zero_i_q);
			pend_wdata = '0;
		end

		qry_we    = accept && as_q && (32'(cnt_base) < DIM);
		qry_waddr = cnt_base[DIMI_W-1:0];
		qry_raddr = qi_q[DIMI_W-1:0];

		pq_we    = 1'b0;
		pq_wdata = '{rm: 1'b0, id: id_q};
		if (accept && cmd == cvs_pkg::CMD_REMOVE && !pend_full) begin
			pq_we    = 1'b1;
			pq_wdata = '{rm: 1'b1, id: item_id};
		end else if (accept && cmd == cvs_pkg::CMD_ADD && last_element && dims_ok &&
			!pend_full && 32'(dims_q) >= DIM) begin
			pq_we    = 1'b1;
			pq_wdata = '{rm: 1'b0, id: item_id};
		end else if (state_q == S_ZERO && 32'(zero_i_q) == DIM - 1) begin
			pq_we = 1'b1;
		end
	end

	// Payload stores without reset: staged op list and the ranked list.
	always_ff @(posedge clk) begin
		if (pq_we) begin
			pend_ops[fill_q[PI_W-1:0]] <= pq_wdata;
		end
		if (state_q == S_Q_INS && ins_ok) begin
			for (int p = 1; p < TOPK; p++) begin
				if (32'(ins_j) < p) begin
					best_sc[p] <= best_sc[p-1];
					best_id[p] <= best_id[p-1];
				end
			end
			for (int p = 0; p < TOPK; p++) begin
				if (32'(ins_j) == p) begin
					best_sc[p] <= score_q;
					best_id[p] <= sid_q;
				end
			end
		end
	end

	// Control sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			dims_q      <= 8'd128;
			cnt_q       <= '0;
			gq_q        <= 1'b0;
			fill_q      <= '0;
			status_q    <= cvs_pkg::ST_OK;
			id_q        <= '0;
			limit_q     <= '0;
			found_q     <= '0;
			out_i_q     <= '0;
			zero_i_q    <= '0;
			clr_q       <= '0;
			op_i_q      <= '0;
			op_rm_q     <= 1'b0;
			op_id_q     <= '0;
			fail_q      <= 1'b0;
			iss_q       <= '0;
			rdv_s1      <= 1'b0;
			rda_s1      <= '0;
			free_v_q    <= 1'b0;
			free_a_q    <= '0;
			tgt_q       <= '0;
			cp_i_q      <= '0;
			cpv_s1      <= 1'b0;
			cpa_s1      <= '0;
			slot_q      <= '0;
			sid_q       <= '0;
			base_q      <= '0;
			qi_q        <= '0;
			qv_s1       <= 1'b0;
			v_s2        <= 1'b0;
			pd_s2       <= '0;
			pa_s2       <= '0;
			pb_s2       <= '0;
			dot_q       <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			sqa_q       <= '0;
			sqb_q       <= '0;
			bit_q       <= '0;
			step_q      <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			dsh_q       <= '0;
			quo_q       <= '0;
			score_q     <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= cvs_pkg::ST_OK;
			out_id_q    <= '0;
			out_sc_q    <= '0;
			out_rank_q  <= '0;
			out_fin_q   <= 1'b0;
			out_pend_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dims_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CAP_W'(CAP - 1)) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (accept) begin
						case (cmd)
							cvs_pkg::CMD_ADD,
							cvs_pkg::CMD_QUERY: begin
								gq_q  <= as_q;
								cnt_q <= last_element ? '0 : cnt_new;
								if (last_element) begin
									id_q    <= item_id;
									state_q <= S_EMIT;
									if (!dims_ok) begin
										status_q <= cvs_pkg::ST_DIM;
									end else if (as_q) begin
										limit_q <= lim_sat;
										if (lim_sat == '0) begin
											status_q <= cvs_pkg::ST_NO_MATCH;
										end else begin
											found_q <= '0;
											slot_q  <= '0;
											state_q <= S_Q_SLOT;
										end
									end else if (pend_full) begin
										status_q <= cvs_pkg::ST_PEND_FULL;
									end else if (32'(dims_q) < DIM) begin
										zero_i_q <= CNT_W'(dims_q);
										state_q  <= S_ZERO;
									end else begin
										status_q <= cvs_pkg::ST_OK;
										fill_q   <= fill_q + 1'b1;
									end
								end
							end
							cvs_pkg::CMD_REMOVE: begin
								cnt_q   <= '0;
								state_q <= S_EMIT;
								if (pend_full) begin
									status_q <= cvs_pkg::ST_PEND_FULL;
								end else begin
									status_q <= cvs_pkg::ST_OK;
									fill_q   <= fill_q + 1'b1;
								end
							end
							cvs_pkg::CMD_COMMIT: begin
								cnt_q    <= '0;
								op_i_q   <= '0;
								fail_q   <= 1'b0;
								status_q <= cvs_pkg::ST_OK;
								state_q  <= (fill_q == '0) ? S_EMIT : S_CM_OP;
							end
							cvs_pkg::CMD_ROLLBACK: begin
								cnt_q    <= '0;
								fill_q   <= '0;
								status_q <= cvs_pkg::ST_OK;
								state_q  <= S_EMIT;
							end
							default: begin
								// undefined command: drop it
							end
						endcase
					end
				end

				S_ZERO: begin
					zero_i_q <= zero_i_q + 1'b1;
					if (32'(zero_i_q) == DIM - 1) begin
						fill_q   <= fill_q + 1'b1;
						status_q <= cvs_pkg::ST_OK;
						state_q  <= S_EMIT;
					end
				end

				S_EMIT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						out_st_q    <= status_q;
						out_id_q    <= '0;
						out_sc_q    <= '0;
						out_rank_q  <= '0;
						out_fin_q   <= 1'b1;
						out_pend_q  <= 5'(fill_q);
						state_q     <= S_IDLE;
					end
				end

				S_CM_OP: begin
					op_rm_q  <= pend_ops[op_i_q].rm;
					op_id_q  <= pend_ops[op_i_q].id;
					iss_q    <= '0;
					rdv_s1   <= 1'b0;
					free_v_q <= 1'b0;
					state_q  <= S_CM_SCAN;
				end

				S_CM_SCAN: begin
					rdv_s1 <= sc_issue;
					rda_s1 <= iss_q[CAP_W-1:0];
					if (sc_issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (free_here && !free_v_q) begin
						free_v_q <= 1'b1;
						free_a_q <= rda_s1;
					end
					if (cm_copy) begin
						tgt_q   <= cm_tgt;
						cp_i_q  <= '0;
						cpv_s1  <= 1'b0;
						rdv_s1  <= 1'b0;
						state_q <= S_CM_COPY;
					end
				end

				S_CM_COPY: begin
					cpv_s1 <= cp_issue;
					cpa_s1 <= cp_i_q[DIMI_W-1:0];
					if (cp_issue) begin
						cp_i_q <= cp_i_q + 1'b1;
					end
				end

				S_Q_SLOT: begin
					state_q <= S_Q_CHK;
				end

				S_Q_CHK: begin
					if (slot_rd[ID_W]) begin
						sid_q   <= slot_rd[ID_W-1:0];
						base_q  <= EA_W'(slot_q) * EA_W'(DIM);
						qi_q    <= '0;
						qv_s1   <= 1'b0;
						v_s2    <= 1'b0;
						dot_q   <= '0;
						na_q    <= '0;
						nb_q    <= '0;
						state_q <= S_Q_ACC;
					end else if (slot_q == CAP_W'(CAP - 1)) begin
						out_i_q <= '0;
						state_q <= S_Q_OUT;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_Q_SLOT;
					end
				end

				S_Q_ACC: begin
					qv_s1 <= q_issue;
					if (q_issue) begin
						qi_q <= qi_q + 1'b1;
					end
					v_s2  <= qv_s1;
					pd_s2 <= qs * es;
					pa_s2 <= 32'(qs * qs);
					pb_s2 <= 32'(es * es);
					if (v_s2) begin
						dot_q <= dot_q + ACC_W'(pd_s2);
						na_q  <= na_q + ACC_W'(pa_s2);
						nb_q  <= nb_q + ACC_W'(pb_s2);
					end
					if (!q_issue && !qv_s1 && !v_s2) begin
						if (na_q == '0 || nb_q == '0) begin
							score_q <= '0;
							state_q <= S_Q_INS;
						end else begin
							sqa_q   <= '{x: na_q, r: '0};
							sqb_q   <= '{x: nb_q, r: '0};
							bit_q   <= ACC_W'(1) << (2 * (cvs_pkg::SQ_STEPS - 1));
							step_q  <= '0;
							state_q <= S_Q_SQRT;
						end
					end
				end

				S_Q_SQRT: begin
					sqa_q  <= sqa_n;
					sqb_q  <= sqb_n;
					bit_q  <= bit_q >> 2;
					step_q <= step_q + 1'b1;
					if (32'(step_q) == cvs_pkg::SQ_STEPS - 1) begin
						state_q <= S_Q_MUL;
					end
				end

				S_Q_MUL: begin
					den_q   <= DEN_W'(sqa_q.r[SQ_W-1:0]) * DEN_W'(sqb_q.r[SQ_W-1:0]);
					state_q <= S_Q_DINIT;
				end

				S_Q_DINIT: begin
					// round half up in magnitude: add half the divisor first
					rem_q   <= (DIV_W'(mag) << 16) + DIV_W'(den_q >> 1);
					dsh_q   <= DIV_W'(den_q) << (Q_W - 1);
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= S_Q_DIV;
				end

				S_Q_DIV: begin
					if (dge) begin
						rem_q <= dsub;
					end
					quo_q  <= {quo_q[Q_W-2:0], dge};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 1'b1;
					if (32'(step_q) == Q_W - 1) begin
						state_q <= S_Q_FIN;
					end
				end

				S_Q_FIN: begin
					score_q <= dot_q[ACC_W-1] ? -SC_W'(qsat) : SC_W'(qsat);
					state_q <= S_Q_INS;
				end

				S_Q_INS: begin
					if (ins_ok && found_q < limit_q) begin
						found_q <= found_q + 1'b1;
					end
					if (slot_q == CAP_W'(CAP - 1)) begin
						out_i_q <= '0;
						state_q <= S_Q_OUT;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_Q_SLOT;
					end
				end

				S_Q_OUT: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						out_pend_q  <= 5'(fill_q);
						if (found_q == '0) begin
							out_st_q   <= cvs_pkg::ST_NO_MATCH;
							out_id_q   <= '0;
							out_sc_q   <= '0;
							out_rank_q <= '0;
							out_fin_q  <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							out_st_q   <= cvs_pkg::ST_OK;
							out_id_q   <= best_id[out_i_q[KW-2:0]];
							out_sc_q   <= best_sc[out_i_q[KW-2:0]];
							out_rank_q <= RANK_W'(out_i_q);
							out_fin_q  <= (out_i_q + 1'b1 == found_q);
							out_i_q    <= out_i_q + 1'b1;
							if (out_i_q + 1'b1 == found_q) begin
								state_q <= S_IDLE;
							end
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// advance to the next staged op, or close the commit
			if (cm_next) begin
				if (cm_fail) begin
					fail_q <= 1'b1;
				end
				rdv_s1 <= 1'b0;
				if (PD_W'(op_i_q) + 1'b1 == fill_q) begin
					fill_q   <= '0;
					status_q <= (fail_q || cm_fail) ? cvs_pkg::ST_STORE_FULL : cvs_pkg::ST_OK;
					state_q  <= S_EMIT;
				end else begin
					op_i_q  <= op_i_q + 1'b1;
					state_q <= S_CM_OP;
				end
			end
		end
	end

	cvs_ram #(.WIDTH(ID_W + 1), .DEPTH(CAP)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	cvs_ram #(.WIDTH(EL_W), .DEPTH(CAP * DIM)) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (pend_rd),
		.raddr (elem_raddr),
		.rdata (elem_rd)
	);

	cvs_ram #(.WIDTH(EL_W), .DEPTH(PD * DIM)) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (pend_wdata),
		.raddr (pend_raddr),
		.rdata (pend_rd)
	);

	cvs_ram #(.WIDTH(EL_W), .DEPTH(DIM)) u_qry_ram (
		.clk   (clk),
		.we    (qry_we),
		.waddr (qry_waddr),
		.wdata (element),
		.raddr (qry_raddr),
		.rdata (qry_rd)
	);

endmodule

[rtl/cvs_checker.sv]
module cvs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [2:0]                      cmd,
	input logic [cvs_pkg::ID_W-1:0]        item_id,
	input logic signed [cvs_pkg::EL_W-1:0] element,
	input logic                            last_element,
	input logic [4:0]                      result_limit,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [2:0]                      status,
	input logic [cvs_pkg::ID_W-1:0]        match_id,
	input logic signed [cvs_pkg::SC_W-1:0] score,
	input logic [cvs_pkg::RANK_W-1:0]      rank,
	input logic                            final_result,
	input logic [4:0]                      pending_total,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [7:0]                      cfg_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_id) && $stable(score) &&
		$stable(status) && $stable(rank) && $stable(final_result))
		else $error("stalled result changed");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cvs_pkg::ST_OK |-> final_result && rank == '0 &&
		match_id == '0 && score == '0)
		else $error("non-match result carries match fields");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> score <= 18'sd65536 && score >= -18'sd65536)
		else $error("score out of range");

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(pending_total) <= cvs_pkg::PEND_DEPTH)
		else $error("pending count out of range");

	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_result |=> out_valid && status == cvs_pkg::ST_OK &&
		rank == $past(rank) + 1'b1)
		else $error("ranked results out of sequence");

endmodule

bind cosine_topk_vector_search cvs_checker u_cvs_checker (.*);
